@@ rtl/tfc_pkg.sv @@
// tfc_pkg: widths, register indexes, payload and flow-control types for transform_compose
// used by tfc_flow and transform_compose; no dependencies
package tfc_pkg;

	localparam int TRANS_W    = 32;
	localparam int QUAT_W     = 16;
	localparam int SCALE_W    = 16;
	localparam int Q_FRAC     = 14;
	localparam int S_FRAC     = 8;
	localparam int NUM_STAGES = 6;
	localparam int CFG_W      = TRANS_W;
	localparam int CFG_IDX_W  = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PARENT_TX    = 4'd0,
		REG_PARENT_TY    = 4'd1,
		REG_PARENT_TZ    = 4'd2,
		REG_PARENT_QX    = 4'd3,
		REG_PARENT_QY    = 4'd4,
		REG_PARENT_QZ    = 4'd5,
		REG_PARENT_QW    = 4'd6,
		REG_PARENT_SCALE = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [TRANS_W-1:0] child_tx;
		logic signed [TRANS_W-1:0] child_ty;
		logic signed [TRANS_W-1:0] child_tz;
		logic signed [QUAT_W-1:0]  child_qx;
		logic signed [QUAT_W-1:0]  child_qy;
		logic signed [QUAT_W-1:0]  child_qz;
		logic signed [QUAT_W-1:0]  child_qw;
		logic        [SCALE_W-1:0] child_scale;
	} child_t;

	typedef struct packed {
		logic signed [TRANS_W-1:0] out_tx;
		logic signed [TRANS_W-1:0] out_ty;
		logic signed [TRANS_W-1:0] out_tz;
		logic signed [QUAT_W-1:0]  out_qx;
		logic signed [QUAT_W-1:0]  out_qy;
		logic signed [QUAT_W-1:0]  out_qz;
		logic signed [QUAT_W-1:0]  out_qw;
		logic        [SCALE_W-1:0] out_scale;
		logic                      saturated;
	} result_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} flow_t;

endpackage

@@ rtl/tfc_flow.sv @@
// tfc_flow: per-stage valid bits and load enables for the transform_compose pipeline
// depends on tfc_pkg; a bubble in any stage is filled even while the output is stalled
module tfc_flow (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           child_valid,
	input  logic           result_stall,
	output tfc_pkg::flow_t flow
);

	localparam int N = tfc_pkg::NUM_STAGES;

	logic [N-1:0] vld_s;
	logic [N-1:0] en;
	logic         in_acc;
	logic         out_acc;

	always_comb begin
		en[N-1] = !vld_s[N-1] || !result_stall;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= child_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign flow.en  = en;
	assign flow.vld = vld_s;

	assign in_acc  = child_valid && en[0];
	assign out_acc = vld_s[N-1] && !result_stall;

	// input held off only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!en[0] |-> (&vld_s))
		else $error("input stalled with a bubble in the pipeline");

	a_empty_first: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[0] |-> en[0])
		else $error("empty first stage not loadable");

	// occupancy tracks requests in minus requests out
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld_s) ==
			$past($countones(vld_s)) + $past(in_acc) - $past(out_acc)))
		else $error("request lost or duplicated in pipeline");

endmodule

@@ rtl/transform_compose.sv @@
// transform_compose: composes a configured parent similarity transform with a stream
// of child transforms. Channels: child (child_valid, child_stall, child) carries one
// request per accepted cycle; result (result_valid, result_stall, result) returns one
// composed transform per request, in order. Both use valid/stall: a request moves at a
// rising edge where valid is high and stall is low.
// The pipeline takes one request per cycle while the result side does not stall. The
// six stages are: parent quaternion times child translation and quaternion, and scale
// product; rounding of the first rotation half, quaternion and scale; the second
// rotation multiply; its rounding; the parent scale multiply; the final add and clip.
// A stall on the result side holds the last stage; earlier stages keep filling empty
// slots, so child_stall rises only when all six stages hold a request.
// Parent registers are written via cfg_we, cfg_index, cfg_data; the user must write
// them only while no request is in flight, which the block itself does not enforce.
// An index past the last register is ignored. Reset (arst_n low) empties the pipeline
// and sets the parent to identity: zero translation, unit quaternion, unit scale.
// depends on tfc_pkg and tfc_flow
module transform_compose (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             child_valid,
	output logic                             child_stall,
	input  tfc_pkg::child_t                  child,
	output logic                             result_valid,
	input  logic                             result_stall,
	output tfc_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [tfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tfc_pkg::CFG_W-1:0]        cfg_data
);

	localparam int TW  = tfc_pkg::TRANS_W;
	localparam int QW  = tfc_pkg::QUAT_W;
	localparam int SW  = tfc_pkg::SCALE_W;
	localparam int QF  = tfc_pkg::Q_FRAC;
	localparam int SF  = tfc_pkg::S_FRAC;
	localparam int NS  = tfc_pkg::NUM_STAGES;

	localparam int PV_W    = TW + QW;
	localparam int U_SUM_W = PV_W + 2;
	localparam int U_W     = U_SUM_W - QF;
	localparam int UQ_W    = U_W + QW;
	localparam int R_SUM_W = UQ_W + 2;
	localparam int R_W     = R_SUM_W - QF;
	localparam int RS_W    = R_W + SW + 1;
	localparam int RT_W    = RS_W - SF;
	localparam int T_SUM_W = RT_W + 1;
	localparam int QQ_W    = 2 * QW;
	localparam int QS_W    = QQ_W + 2;
	localparam int SS_W    = 2 * SW;

	localparam logic signed [U_SUM_W-1:0] U_HALF =
		{{(U_SUM_W-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
	localparam logic signed [R_SUM_W-1:0] R_HALF =
		{{(R_SUM_W-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
	localparam logic signed [QS_W-1:0] Q_HALF =
		{{(QS_W-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
	localparam logic signed [RS_W-1:0] T_HALF =
		{{(RS_W-SF){1'b0}}, 1'b1, {(SF-1){1'b0}}};
	localparam logic [SS_W:0] S_HALF =
		{{(SS_W+1-SF){1'b0}}, 1'b1, {(SF-1){1'b0}}};

	localparam logic signed [QS_W-1:0] Q_MAX = {{(QS_W-QW+1){1'b0}}, {(QW-1){1'b1}}};
	localparam logic signed [QS_W-1:0] Q_MIN = {{(QS_W-QW+1){1'b1}}, {(QW-1){1'b0}}};
	localparam logic signed [T_SUM_W-1:0] T_MAX =
		{{(T_SUM_W-TW+1){1'b0}}, {(TW-1){1'b1}}};
	localparam logic signed [T_SUM_W-1:0] T_MIN =
		{{(T_SUM_W-TW+1){1'b1}}, {(TW-1){1'b0}}};
	localparam logic [SS_W:0] S_MAX = {{(SS_W+1-SW){1'b0}}, {SW{1'b1}}};

	// parent registers
	logic signed [TW-1:0] parent_tx_q, parent_ty_q, parent_tz_q;
	logic signed [QW-1:0] parent_qx_q, parent_qy_q, parent_qz_q, parent_qw_q;
	logic        [SW-1:0] parent_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_tx_q    <= '0;
			parent_ty_q    <= '0;
			parent_tz_q    <= '0;
			parent_qx_q    <= '0;
			parent_qy_q    <= '0;
			parent_qz_q    <= '0;
			parent_qw_q    <= QW'(1 << QF);
			parent_scale_q <= SW'(1 << SF);
		end else if (cfg_we) begin
			unique case (tfc_pkg::reg_idx_t'(cfg_index))
				tfc_pkg::REG_PARENT_TX:    parent_tx_q    <= cfg_data[TW-1:0];
				tfc_pkg::REG_PARENT_TY:    parent_ty_q    <= cfg_data[TW-1:0];
				tfc_pkg::REG_PARENT_TZ:    parent_tz_q    <= cfg_data[TW-1:0];
				tfc_pkg::REG_PARENT_QX:    parent_qx_q    <= cfg_data[QW-1:0];
				tfc_pkg::REG_PARENT_QY:    parent_qy_q    <= cfg_data[QW-1:0];
				tfc_pkg::REG_PARENT_QZ:    parent_qz_q    <= cfg_data[QW-1:0];
				tfc_pkg::REG_PARENT_QW:    parent_qw_q    <= cfg_data[QW-1:0];
				tfc_pkg::REG_PARENT_SCALE: parent_scale_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	tfc_pkg::flow_t flow;

	tfc_flow u_flow (
		.clk          (clk),
		.arst_n       (arst_n),
		.child_valid  (child_valid),
		.result_stall (result_stall),
		.flow         (flow)
	);

	assign child_stall  = !flow.en[0];
	assign result_valid = flow.vld[NS-1];

	logic signed [SW:0] ps_ext;
	assign ps_ext = $signed({1'b0, parent_scale_q});

	// stage 1: products
	logic signed [PV_W-1:0] pv_s1 [4][3];
	logic signed [QQ_W-1:0] qq_s1 [4][4];
	logic        [SS_W-1:0] ss_s1;

	always_ff @(posedge clk) begin
		if (flow.en[0]) begin
			pv_s1[0][0] <= parent_qy_q * child.child_tz;
			pv_s1[0][1] <= parent_qz_q * child.child_ty;
			pv_s1[0][2] <= parent_qw_q * child.child_tx;
			pv_s1[1][0] <= parent_qz_q * child.child_tx;
			pv_s1[1][1] <= parent_qx_q * child.child_tz;
			pv_s1[1][2] <= parent_qw_q * child.child_ty;
			pv_s1[2][0] <= parent_qx_q * child.child_ty;
			pv_s1[2][1] <= parent_qy_q * child.child_tx;
			pv_s1[2][2] <= parent_qw_q * child.child_tz;
			pv_s1[3][0] <= parent_qx_q * child.child_tx;
			pv_s1[3][1] <= parent_qy_q * child.child_ty;
			pv_s1[3][2] <= parent_qz_q * child.child_tz;

			qq_s1[0][0] <= parent_qy_q * child.child_qz;
			qq_s1[0][1] <= parent_qz_q * child.child_qy;
			qq_s1[0][2] <= child.child_qw * parent_qx_q;
			qq_s1[0][3] <= parent_qw_q * child.child_qx;
			qq_s1[1][0] <= parent_qz_q * child.child_qx;
			qq_s1[1][1] <= parent_qx_q * child.child_qz;
			qq_s1[1][2] <= child.child_qw * parent_qy_q;
			qq_s1[1][3] <= parent_qw_q * child.child_qy;
			qq_s1[2][0] <= parent_qx_q * child.child_qy;
			qq_s1[2][1] <= parent_qy_q * child.child_qx;
			qq_s1[2][2] <= child.child_qw * parent_qz_q;
			qq_s1[2][3] <= parent_qw_q * child.child_qz;
			qq_s1[3][0] <= parent_qw_q * child.child_qw;
			qq_s1[3][1] <= parent_qx_q * child.child_qx;
			qq_s1[3][2] <= parent_qy_q * child.child_qy;
			qq_s1[3][3] <= parent_qz_q * child.child_qz;

			ss_s1 <= parent_scale_q * child.child_scale;
		end
	end

	// stage 2: first rotation half rounded, quaternion and scale finished
	logic signed [U_SUM_W-1:0] u_sum [4];
	logic signed [U_SUM_W-1:0] u_rnd [4];
	logic signed [QS_W-1:0]    q_sum [4];
	logic signed [QS_W-1:0]    q_rnd [4];
	logic signed [QW-1:0]      q_sat [4];
	logic        [3:0]         q_clip;
	logic        [SS_W:0]      s_rnd;
	logic        [SW-1:0]      s_sat;
	logic                      s_clip;

	always_comb begin
		u_sum[0] = pv_s1[0][0] - pv_s1[0][1] + pv_s1[0][2];
		u_sum[1] = pv_s1[1][0] - pv_s1[1][1] + pv_s1[1][2];
		u_sum[2] = pv_s1[2][0] - pv_s1[2][1] + pv_s1[2][2];
		u_sum[3] = -pv_s1[3][0] - pv_s1[3][1] - pv_s1[3][2];
		q_sum[0] = qq_s1[0][0] - qq_s1[0][1] + qq_s1[0][2] + qq_s1[0][3];
		q_sum[1] = qq_s1[1][0] - qq_s1[1][1] + qq_s1[1][2] + qq_s1[1][3];
		q_sum[2] = qq_s1[2][0] - qq_s1[2][1] + qq_s1[2][2] + qq_s1[2][3];
		q_sum[3] = qq_s1[3][0] - qq_s1[3][1] - qq_s1[3][2] - qq_s1[3][3];
		for (int i = 0; i < 4; i++) begin
			u_rnd[i] = (u_sum[i] + U_HALF) >>> QF;
			q_rnd[i] = (q_sum[i] + Q_HALF) >>> QF;
			q_clip[i] = (q_rnd[i] > Q_MAX) || (q_rnd[i] < Q_MIN);
			if (q_rnd[i] > Q_MAX) begin
				q_sat[i] = Q_MAX[QW-1:0];
			end else if (q_rnd[i] < Q_MIN) begin
				q_sat[i] = Q_MIN[QW-1:0];
			end else begin
				q_sat[i] = q_rnd[i][QW-1:0];
			end
		end
		s_rnd  = ({1'b0, ss_s1} + S_HALF) >> SF;
		s_clip = s_rnd > S_MAX;
		s_sat  = s_clip ? S_MAX[SW-1:0] : s_rnd[SW-1:0];
	end

	logic signed [U_W-1:0] u_s2 [4];
	tfc_pkg::result_t      res_s2;

	always_ff @(posedge clk) begin
		if (flow.en[1]) begin
			for (int i = 0; i < 4; i++) begin
				u_s2[i] <= u_rnd[i][U_W-1:0];
			end
			res_s2.out_tx    <= '0;
			res_s2.out_ty    <= '0;
			res_s2.out_tz    <= '0;
			res_s2.out_qx    <= q_sat[0];
			res_s2.out_qy    <= q_sat[1];
			res_s2.out_qz    <= q_sat[2];
			res_s2.out_qw    <= q_sat[3];
			res_s2.out_scale <= s_sat;
			res_s2.saturated <= (|q_clip) || s_clip;
		end
	end

	// stage 3: second rotation half products
	logic signed [UQ_W-1:0] uq_s3 [3][4];
	tfc_pkg::result_t       res_s3;

	always_ff @(posedge clk) begin
		if (flow.en[2]) begin
			uq_s3[0][0] <= u_s2[1] * parent_qz_q;
			uq_s3[0][1] <= u_s2[2] * parent_qy_q;
			uq_s3[0][2] <= parent_qw_q * u_s2[0];
			uq_s3[0][3] <= u_s2[3] * parent_qx_q;
			uq_s3[1][0] <= u_s2[2] * parent_qx_q;
			uq_s3[1][1] <= u_s2[0] * parent_qz_q;
			uq_s3[1][2] <= parent_qw_q * u_s2[1];
			uq_s3[1][3] <= u_s2[3] * parent_qy_q;
			uq_s3[2][0] <= u_s2[0] * parent_qy_q;
			uq_s3[2][1] <= u_s2[1] * parent_qx_q;
			uq_s3[2][2] <= parent_qw_q * u_s2[2];
			uq_s3[2][3] <= u_s2[3] * parent_qz_q;
			res_s3      <= res_s2;
		end
	end

	// stage 4: rotated translation rounded
	logic signed [R_SUM_W-1:0] r_sum [3];
	logic signed [R_SUM_W-1:0] r_rnd [3];
	logic signed [R_W-1:0]     r_s4  [3];
	tfc_pkg::result_t          res_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_sum[i] = -uq_s3[i][0] + uq_s3[i][1] + uq_s3[i][2] - uq_s3[i][3];
			r_rnd[i] = (r_sum[i] + R_HALF) >>> QF;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.en[3]) begin
			for (int i = 0; i < 3; i++) begin
				r_s4[i] <= r_rnd[i][R_W-1:0];
			end
			res_s4 <= res_s3;
		end
	end

	// stage 5: parent scale
	logic signed [RS_W-1:0] rs_s5 [3];
	tfc_pkg::result_t       res_s5;

	always_ff @(posedge clk) begin
		if (flow.en[4]) begin
			for (int i = 0; i < 3; i++) begin
				rs_s5[i] <= r_s4[i] * ps_ext;
			end
			res_s5 <= res_s4;
		end
	end

	// stage 6: round, add parent translation, clip
	logic signed [TW-1:0]      pt    [3];
	logic signed [RS_W-1:0]    t_rnd [3];
	logic signed [T_SUM_W-1:0] t_sum [3];
	logic signed [TW-1:0]      t_sat [3];
	logic        [2:0]         t_clip;

	assign pt[0] = parent_tx_q;
	assign pt[1] = parent_ty_q;
	assign pt[2] = parent_tz_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_rnd[i] = (rs_s5[i] + T_HALF) >>> SF;
			t_sum[i] = $signed(t_rnd[i][RT_W-1:0]) + pt[i];
			t_clip[i] = (t_sum[i] > T_MAX) || (t_sum[i] < T_MIN);
			if (t_sum[i] > T_MAX) begin
				t_sat[i] = T_MAX[TW-1:0];
			end else if (t_sum[i] < T_MIN) begin
				t_sat[i] = T_MIN[TW-1:0];
			end else begin
				t_sat[i] = t_sum[i][TW-1:0];
			end
		end
	end

	tfc_pkg::result_t res_s6;

	always_ff @(posedge clk) begin
		if (flow.en[5]) begin
			res_s6.out_tx    <= t_sat[0];
			res_s6.out_ty    <= t_sat[1];
			res_s6.out_tz    <= t_sat[2];
			res_s6.out_qx    <= res_s5.out_qx;
			res_s6.out_qy    <= res_s5.out_qy;
			res_s6.out_qz    <= res_s5.out_qz;
			res_s6.out_qw    <= res_s5.out_qw;
			res_s6.out_scale <= res_s5.out_scale;
			res_s6.saturated <= res_s5.saturated || (|t_clip);
		end
	end

	assign result = res_s6;

	// stalled result holds until taken
	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(res_s6))
		else $error("stalled result changed");

	a_child_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		child_stall |-> result_valid && result_stall)
		else $error("input stalled while the output side drains");

	a_flag_covers_scale: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (res_s6.out_scale == S_MAX[SW-1:0]) && !res_s6.saturated
			|-> (parent_scale_q != '0))
		else $error("scale clipped without saturation flag");

endmodule

@@ tb/transform_compose_tb.sv @@
`timescale 1ns / 1ps
// transform_compose_tb: random and directed check of parent/child transform composition
// a scoreboard class predicts each composed transform; tasks drive child and config ports
// depends on tfc_pkg and the transform_compose RTL
module transform_compose_tb;

	localparam int NUM_REGS = int'(tfc_pkg::REG_PARENT_SCALE) + 1;
	localparam logic [tfc_pkg::TRANS_W-1:0] T_MAX = {1'b0, {(tfc_pkg::TRANS_W-1){1'b1}}};
	localparam logic [tfc_pkg::TRANS_W-1:0] T_MIN = {1'b1, {(tfc_pkg::TRANS_W-1){1'b0}}};
	localparam logic [tfc_pkg::QUAT_W-1:0]  Q_MAX = {1'b0, {(tfc_pkg::QUAT_W-1){1'b1}}};
	localparam logic [tfc_pkg::QUAT_W-1:0]  Q_MIN = {1'b1, {(tfc_pkg::QUAT_W-1){1'b0}}};
	localparam logic [tfc_pkg::QUAT_W-1:0]  Q_ONE =
		tfc_pkg::QUAT_W'(1 << tfc_pkg::Q_FRAC);
	localparam logic [tfc_pkg::QUAT_W-1:0]  Q_RT_HALF = tfc_pkg::QUAT_W'(11585);
	localparam logic [tfc_pkg::QUAT_W-1:0]  Q_HALF = tfc_pkg::QUAT_W'(Q_ONE / 2);
	localparam logic [tfc_pkg::SCALE_W-1:0] S_ONE =
		tfc_pkg::SCALE_W'(1 << tfc_pkg::S_FRAC);
	localparam logic [tfc_pkg::SCALE_W-1:0] S_MAX = '1;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 90;

	class compose_sb;
		logic signed [tfc_pkg::TRANS_W-1:0] ptx, pty, ptz;
		logic signed [tfc_pkg::QUAT_W-1:0]  pqx, pqy, pqz, pqw;
		logic        [tfc_pkg::SCALE_W-1:0] pscale;
		tfc_pkg::result_t composed_q[$];
		int mismatches;

		function new();
			ptx = '0;
			pty = '0;
			ptz = '0;
			pqx = '0;
			pqy = '0;
			pqz = '0;
			pqw = Q_ONE;
			pscale = S_ONE;
			mismatches = 0;
		endfunction

		function void write_parent(logic [tfc_pkg::CFG_IDX_W-1:0] idx,
				logic [tfc_pkg::CFG_W-1:0] d);
			case (idx)
				tfc_pkg::REG_PARENT_TX:    ptx = d[tfc_pkg::TRANS_W-1:0];
				tfc_pkg::REG_PARENT_TY:    pty = d[tfc_pkg::TRANS_W-1:0];
				tfc_pkg::REG_PARENT_TZ:    ptz = d[tfc_pkg::TRANS_W-1:0];
				tfc_pkg::REG_PARENT_QX:    pqx = d[tfc_pkg::QUAT_W-1:0];
				tfc_pkg::REG_PARENT_QY:    pqy = d[tfc_pkg::QUAT_W-1:0];
				tfc_pkg::REG_PARENT_QZ:    pqz = d[tfc_pkg::QUAT_W-1:0];
				tfc_pkg::REG_PARENT_QW:    pqw = d[tfc_pkg::QUAT_W-1:0];
				tfc_pkg::REG_PARENT_SCALE: pscale = d[tfc_pkg::SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		function longint rnd(longint x, int k);
			return (x + (longint'(1) <<< (k - 1))) >>> k;
		endfunction

		function longint clip_to(longint x, longint lo, longint hi, inout bit clip);
			if (x < lo) begin
				clip = 1'b1;
				return lo;
			end
			if (x > hi) begin
				clip = 1'b1;
				return hi;
			end
			return x;
		endfunction

		function longint clip_signed(longint x, int w, inout bit clip);
			longint hi;
			hi = (longint'(1) <<< (w - 1)) - 1;
			return clip_to(x, -hi - 1, hi, clip);
		endfunction

		function tfc_pkg::result_t compose_child(tfc_pkg::child_t c);
			longint px, py, pz, pw, cx, cy, cz, cw, vx, vy, vz;
			longint ux, uy, uz, uw, rx, ry, rz, ps, cs, t;
			tfc_pkg::result_t o;
			bit clip;
			clip = 1'b0;
			px = longint'($signed(pqx));
			py = longint'($signed(pqy));
			pz = longint'($signed(pqz));
			pw = longint'($signed(pqw));
			cx = longint'($signed(c.child_qx));
			cy = longint'($signed(c.child_qy));
			cz = longint'($signed(c.child_qz));
			cw = longint'($signed(c.child_qw));
			vx = longint'($signed(c.child_tx));
			vy = longint'($signed(c.child_ty));
			vz = longint'($signed(c.child_tz));
			ps = longint'({1'b0, pscale});
			cs = longint'({1'b0, c.child_scale});

			// rotate the child translation: q * (v, 0) * conj(q)
			ux = rnd(py * vz - pz * vy + pw * vx, tfc_pkg::Q_FRAC);
			uy = rnd(pz * vx - px * vz + pw * vy, tfc_pkg::Q_FRAC);
			uz = rnd(px * vy - py * vx + pw * vz, tfc_pkg::Q_FRAC);
			uw = rnd(-px * vx - py * vy - pz * vz, tfc_pkg::Q_FRAC);
			rx = rnd(-uy * pz + uz * py + pw * ux - uw * px, tfc_pkg::Q_FRAC);
			ry = rnd(-uz * px + ux * pz + pw * uy - uw * py, tfc_pkg::Q_FRAC);
			rz = rnd(-ux * py + uy * px + pw * uz - uw * pz, tfc_pkg::Q_FRAC);

			t = clip_signed(longint'($signed(ptx)) + rnd(rx * ps, tfc_pkg::S_FRAC),
				tfc_pkg::TRANS_W, clip);
			o.out_tx = t[tfc_pkg::TRANS_W-1:0];
			t = clip_signed(longint'($signed(pty)) + rnd(ry * ps, tfc_pkg::S_FRAC),
				tfc_pkg::TRANS_W, clip);
			o.out_ty = t[tfc_pkg::TRANS_W-1:0];
			t = clip_signed(longint'($signed(ptz)) + rnd(rz * ps, tfc_pkg::S_FRAC),
				tfc_pkg::TRANS_W, clip);
			o.out_tz = t[tfc_pkg::TRANS_W-1:0];

			// hamilton product parent * child
			t = clip_signed(rnd(py * cz - pz * cy + cw * px + pw * cx, tfc_pkg::Q_FRAC),
				tfc_pkg::QUAT_W, clip);
			o.out_qx = t[tfc_pkg::QUAT_W-1:0];
			t = clip_signed(rnd(pz * cx - px * cz + cw * py + pw * cy, tfc_pkg::Q_FRAC),
				tfc_pkg::QUAT_W, clip);
			o.out_qy = t[tfc_pkg::QUAT_W-1:0];
			t = clip_signed(rnd(px * cy - py * cx + cw * pz + pw * cz, tfc_pkg::Q_FRAC),
				tfc_pkg::QUAT_W, clip);
			o.out_qz = t[tfc_pkg::QUAT_W-1:0];
			t = clip_signed(rnd(pw * cw - px * cx - py * cy - pz * cz, tfc_pkg::Q_FRAC),
				tfc_pkg::QUAT_W, clip);
			o.out_qw = t[tfc_pkg::QUAT_W-1:0];

			t = clip_to(rnd(ps * cs, tfc_pkg::S_FRAC), 0, longint'(S_MAX), clip);
			o.out_scale = t[tfc_pkg::SCALE_W-1:0];
			o.saturated = clip;
			return o;
		endfunction

		function void note_child(tfc_pkg::child_t c);
			composed_q.push_back(compose_child(c));
		endfunction

		function void report(string what, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
		endfunction

		function void cmp_field(string what, logic [63:0] want, logic [63:0] got);
			if (want !== got)
				report(what, want, got);
		endfunction

		function void check_composed(tfc_pkg::result_t got);
			tfc_pkg::result_t want;
			if (composed_q.size() == 0) begin
				report("unexpected result", '0, got[63:0]);
				return;
			end
			want = composed_q.pop_front();
			cmp_field("out_tx", 64'(want.out_tx), 64'(got.out_tx));
			cmp_field("out_ty", 64'(want.out_ty), 64'(got.out_ty));
			cmp_field("out_tz", 64'(want.out_tz), 64'(got.out_tz));
			cmp_field("out_qx", 64'(want.out_qx), 64'(got.out_qx));
			cmp_field("out_qy", 64'(want.out_qy), 64'(got.out_qy));
			cmp_field("out_qz", 64'(want.out_qz), 64'(got.out_qz));
			cmp_field("out_qw", 64'(want.out_qw), 64'(got.out_qw));
			cmp_field("out_scale", 64'(want.out_scale), 64'(got.out_scale));
			cmp_field("saturated", 64'(want.saturated), 64'(got.saturated));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic child_valid = 1'b0;
	logic child_stall;
	tfc_pkg::child_t child = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	tfc_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [tfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tfc_pkg::CFG_W-1:0] cfg_data = '0;

	compose_sb sb;
	int child_gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;

	transform_compose i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.child_valid  (child_valid),
		.child_stall  (child_stall),
		.child        (child),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// result side stall in runs
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			result_stall <= 1'b1;
			stall_left = idle_len();
		end else begin
			result_stall <= 1'b0;
			stall_left = $urandom_range(0, 8);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (child_valid === 1'b1 && child_stall === 1'b0)
				sb.note_child(child);
			if (result_valid === 1'b1 && result_stall === 1'b0)
				sb.check_composed(result);
		end
	end

	function automatic logic [tfc_pkg::TRANS_W-1:0] rand_trans();
		case ($urandom_range(0, 9))
			0: return T_MAX;
			1: return T_MIN;
			2: return '0;
			3, 4: return $urandom_range(0, 1 << 21) - (1 << 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [tfc_pkg::QUAT_W-1:0] rand_quat();
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return Q_ONE;
			4: return -Q_ONE;
			5, 6, 7: return tfc_pkg::QUAT_W'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
			default: return tfc_pkg::QUAT_W'($urandom);
		endcase
	endfunction

	function automatic logic [tfc_pkg::SCALE_W-1:0] rand_scale();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return S_MAX;
			2: return S_ONE;
			3, 4, 5: return tfc_pkg::SCALE_W'($urandom_range(0, 4 * S_ONE));
			default: return tfc_pkg::SCALE_W'($urandom);
		endcase
	endfunction

	function automatic tfc_pkg::child_t mk_child(logic [tfc_pkg::TRANS_W-1:0] tx,
			logic [tfc_pkg::TRANS_W-1:0] ty, logic [tfc_pkg::TRANS_W-1:0] tz,
			logic [tfc_pkg::QUAT_W-1:0] qx, logic [tfc_pkg::QUAT_W-1:0] qy,
			logic [tfc_pkg::QUAT_W-1:0] qz, logic [tfc_pkg::QUAT_W-1:0] qw,
			logic [tfc_pkg::SCALE_W-1:0] s);
		tfc_pkg::child_t c;
		c.child_tx = tx;
		c.child_ty = ty;
		c.child_tz = tz;
		c.child_qx = qx;
		c.child_qy = qy;
		c.child_qz = qz;
		c.child_qw = qw;
		c.child_scale = s;
		return c;
	endfunction

	localparam int NUM_DIRECTED = 12;

	function automatic tfc_pkg::child_t directed_child(int n);
		case (n)
			0: return mk_child('0, '0, '0, '0, '0, '0, '0, '0);
			1: return mk_child('0, '0, '0, '0, '0, '0, Q_ONE, S_ONE);
			2: return mk_child(T_MAX, T_MAX, T_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, S_MAX);
			3: return mk_child(T_MIN, T_MIN, T_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0);
			4: return mk_child(T_MAX, T_MIN, '0, Q_ONE, '0, '0, '0,
				tfc_pkg::SCALE_W'(1));
			5: return mk_child(1, -1, 'h8000, '0, Q_ONE, '0, Q_ONE, tfc_pkg::SCALE_W'(1));
			6: return mk_child(T_MAX, T_MAX, T_MIN, -Q_ONE, '0, '0, '0, S_MAX);
			7: return mk_child(32'h1_0000, 32'h2_0000, 32'h3_0000, '0, Q_ONE, '0, '0,
				tfc_pkg::SCALE_W'(2 * S_ONE));
			8: return mk_child(-32'h1_0000, 'h8000, -'h8000, '0, '0, Q_ONE, '0,
				tfc_pkg::SCALE_W'(S_ONE / 2));
			9: return mk_child(32'h1_0000, '0, '0, Q_RT_HALF, '0, '0, Q_RT_HALF,
				tfc_pkg::SCALE_W'(3 * S_ONE / 2));
			10: return mk_child($urandom, $urandom, $urandom, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
				tfc_pkg::SCALE_W'(1));
			default: return mk_child(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 16'h5555,
				16'haaaa, 16'h5555, 16'haaaa, 16'haaaa);
		endcase
	endfunction

	function automatic tfc_pkg::child_t random_child();
		return mk_child(rand_trans(), rand_trans(), rand_trans(), rand_quat(), rand_quat(),
			rand_quat(), rand_quat(), rand_scale());
	endfunction

	function automatic logic [tfc_pkg::CFG_W-1:0] pad_upper(logic [tfc_pkg::QUAT_W-1:0] v);
		logic [tfc_pkg::CFG_W-1:0] w;
		w = $urandom;
		w[tfc_pkg::QUAT_W-1:0] = v;
		return w;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 40;
			default: return 70;
		endcase
	endfunction

	task automatic send_child(input tfc_pkg::child_t c);
		child_valid <= 1'b1;
		child <= c;
		@(posedge clk);
		while (child_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic run_children(input int n, input bit directed);
		int gap;
		for (int i = 0; i < n; i++) begin
			send_child(directed ? directed_child(i) : random_child());
			gap = ($urandom_range(0, 99) < child_gap_pct) ? idle_len() : 0;
			if (gap != 0) begin
				child_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		child_valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (sb.composed_q.size() != 0)
			@(posedge clk);
	endtask

	// writes every register, then one write to an unused index that must be ignored
	task automatic program_parent(input logic [tfc_pkg::CFG_W-1:0] vals [NUM_REGS]);
		tfc_pkg::reg_idx_t r;
		r = r.first();
		do begin
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_data <= vals[r];
			@(posedge clk);
			sb.write_parent(r, vals[r]);
			r = r.next();
		end while (r != r.first());
		cfg_index <= tfc_pkg::CFG_IDX_W'(NUM_REGS +
			$urandom_range(0, (1 << tfc_pkg::CFG_IDX_W) - 1 - NUM_REGS));
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_parent(output logic [tfc_pkg::CFG_W-1:0] vals [NUM_REGS]);
		logic [tfc_pkg::QUAT_W-1:0] q [4];
		case ($urandom_range(0, 5))
			0: q = '{'0, '0, '0, Q_ONE};
			1: q = '{Q_ONE, '0, '0, '0};
			2: q = '{'0, Q_RT_HALF, '0, Q_RT_HALF};
			3: q = '{'0, '0, -Q_RT_HALF, Q_RT_HALF};
			4: q = '{Q_HALF, Q_HALF, Q_HALF, Q_HALF};
			default: q = '{rand_quat(), rand_quat(), rand_quat(), rand_quat()};
		endcase
		vals[tfc_pkg::REG_PARENT_TX] = rand_trans();
		vals[tfc_pkg::REG_PARENT_TY] = rand_trans();
		vals[tfc_pkg::REG_PARENT_TZ] = rand_trans();
		vals[tfc_pkg::REG_PARENT_QX] = pad_upper(q[0]);
		vals[tfc_pkg::REG_PARENT_QY] = pad_upper(q[1]);
		vals[tfc_pkg::REG_PARENT_QZ] = pad_upper(q[2]);
		vals[tfc_pkg::REG_PARENT_QW] = pad_upper(q[3]);
		vals[tfc_pkg::REG_PARENT_SCALE] = pad_upper(rand_scale());
	endtask

	initial begin
		logic [tfc_pkg::CFG_W-1:0] vals [NUM_REGS];
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity parent straight out of reset
		run_children(NUM_DIRECTED, 1'b1);
		drain();

		vals = '{T_MAX, T_MAX, T_MAX, pad_upper(Q_MAX), pad_upper(Q_MAX), pad_upper(Q_MAX),
			pad_upper(Q_MAX), pad_upper(S_MAX)};
		program_parent(vals);
		child_gap_pct = 40;
		stall_pct = 40;
		run_children(NUM_DIRECTED, 1'b1);
		drain();

		vals = '{T_MIN, T_MIN, T_MIN, pad_upper(Q_MIN), pad_upper(Q_MIN), pad_upper(Q_MIN),
			pad_upper(Q_MIN), pad_upper('0)};
		program_parent(vals);
		child_gap_pct = 0;
		stall_pct = 0;
		run_children(60, 1'b0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_parent(vals);
			program_parent(vals);
			child_gap_pct = pick_pct();
			stall_pct = pick_pct();
			run_children(ITEMS_PER_PHASE, 1'b0);
			drain();
		end

		repeat (2 * tfc_pkg::NUM_STAGES) @(posedge clk);
		if (sb.mismatches == 0 && sb.composed_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tfc_pkg.sv
rtl/tfc_flow.sv
rtl/transform_compose.sv
tb/transform_compose_tb.sv
